// ----- hdl/csbk_pkg.sv -----
// Shared types and constants for the control signalling block decoder.
package csbk_pkg;

	// Byte positions within one block
	localparam logic [3:0] CRC_BYTES = 4'd10;
	localparam logic [3:0] LAST_POS  = 4'd11;
	localparam int         STORE_DEPTH = 11;

	// CRC constants
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MASK = 16'hA5A5;

	// Opcode registers
	localparam int         NUM_REGS = 5;
	localparam logic [2:0] REG_LIMIT = 3'd5;

	typedef enum logic [2:0] {
		REG_ACTIVATION  = 3'd0,
		REG_VOICE_REQ   = 3'd1,
		REG_VOICE_ANS   = 3'd2,
		REG_NEG_ACK     = 3'd3,
		REG_PREAMBLE    = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_CRC_ERR   = 3'd1,
		STATUS_PROTECT   = 3'd2,
		STATUS_FEATURE   = 3'd3,
		STATUS_UNKNOWN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		KIND_ACTIVATION = 3'd0,
		KIND_VOICE_REQ  = 3'd1,
		KIND_VOICE_ANS  = 3'd2,
		KIND_NEG_ACK    = 3'd3,
		KIND_PREAMBLE   = 3'd4
	} kind_t;

	// One finished block as handed from the front to the back
	typedef struct packed {
		logic        crc_ok;
		logic [7:0]  byte0;
		logic        feature_nz;
		logic [7:0]  byte3;
		logic [23:0] dst_id;
		logic [23:0] src_id;
	} block_rec_t;

endpackage

// ----- hdl/csbk_front.sv -----
// Front part: collects block bytes, runs the CRC and emits one record per block.
module csbk_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                block_start,
	input  logic                push_ready,
	output logic                push_valid,
	output csbk_pkg::block_rec_t push_rec
);
	import csbk_pkg::*;

	logic [3:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  store_q [STORE_DEPTH];

	logic [3:0]  pos;
	logic [15:0] crc_in;
	logic [15:0] crc_next;
	logic        accept;

	// Bytewise CRC-16 update, most significant bit first
	function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Restart position and CRC on a block start
	assign pos      = block_start ? 4'd0 : count_q;
	assign crc_in   = block_start ? 16'h0000 : crc_q;
	assign crc_next = crc_add_byte(crc_in, data_byte);

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Build the record on the last byte
	assign push_valid         = accept && (pos == LAST_POS);
	assign push_rec.crc_ok    = ((~crc_in ^ CRC_MASK) == {store_q[10], data_byte});
	assign push_rec.byte0     = store_q[0];
	assign push_rec.feature_nz = (store_q[1] != 8'h00);
	assign push_rec.byte3     = store_q[3];
	assign push_rec.dst_id    = {store_q[4], store_q[5], store_q[6]};
	assign push_rec.src_id    = {store_q[7], store_q[8], store_q[9]};

	// Advance count and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			crc_q   <= 16'h0000;
		end else if (accept) begin
			if (pos == LAST_POS) begin
				count_q <= 4'd0;
				crc_q   <= 16'h0000;
			end else begin
				count_q <= pos + 4'd1;
				if (pos < CRC_BYTES) begin
					crc_q <= crc_next;
				end
			end
		end
	end

	// Hold the block bytes
	always_ff @(posedge clk) begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (accept && (pos == 4'(i))) begin
				store_q[i] <= data_byte;
			end
		end
	end

endmodule

// ----- hdl/csbk_fifo.sv -----
// Short queue of block records between the front and the back.
module csbk_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  csbk_pkg::block_rec_t push_rec,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output csbk_pkg::block_rec_t pop_rec
);
	import csbk_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	block_rec_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_rec    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ----- hdl/csbk_back.sv -----
// Back part: holds the opcode registers, classifies a record and drives the result.
module csbk_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  csbk_pkg::block_rec_t pop_rec,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [2:0]           kind,
	output logic [5:0]           opcode,
	output logic                 last_blk,
	output logic [23:0]          dst_id,
	output logic [23:0]          src_id,
	output logic [7:0]           svc_options,
	output logic [7:0]           param_byte,
	output logic                 src_type,
	output logic [5:0]           svc_type,
	output logic                 more_data,
	output logic                 group_call
);
	import csbk_pkg::*;

	logic [5:0] opc_q [NUM_REGS];
	logic       out_valid_q;

	logic [2:0]  status_d;
	logic [2:0]  kind_d;
	logic [5:0]  opcode_d;
	logic        last_blk_d;
	logic [23:0] dst_id_d;
	logic [23:0] src_id_d;
	logic [7:0]  svc_opt_d;
	logic [7:0]  param_d;
	logic        src_type_d;
	logic [5:0]  svc_type_d;
	logic        more_data_d;
	logic        dst_group_d;
	logic        found;
	logic [2:0]  match_idx;
	logic [5:0]  op;
	logic        load;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign load      = pop_valid && (!out_valid_q || out_ready);
	assign pop_ready = !out_valid_q || out_ready;
	assign op        = pop_rec.byte0[5:0];

	// Opcode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opc_q[REG_ACTIVATION] <= 6'd56;
			opc_q[REG_VOICE_REQ]  <= 6'd4;
			opc_q[REG_VOICE_ANS]  <= 6'd5;
			opc_q[REG_NEG_ACK]    <= 6'd38;
			opc_q[REG_PREAMBLE]   <= 6'd61;
		end else if (cfg_valid && cfg_ready && (cfg_index < REG_LIMIT)) begin
			opc_q[cfg_index] <= cfg_data;
		end
	end

	// Find the lowest numbered register matching the opcode
	always_comb begin
		found     = 1'b0;
		match_idx = 3'd0;
		for (int i = NUM_REGS - 1; i >= 0; i--) begin
			if (opc_q[i] == op) begin
				found     = 1'b1;
				match_idx = 3'(i);
			end
		end
	end

	// Classify the record and pick the fields
	always_comb begin
		status_d    = STATUS_OK;
		kind_d      = KIND_ACTIVATION;
		opcode_d    = 6'd0;
		last_blk_d  = 1'b0;
		dst_id_d    = 24'd0;
		src_id_d    = 24'd0;
		svc_opt_d   = 8'd0;
		param_d     = 8'd0;
		src_type_d  = 1'b0;
		svc_type_d  = 6'd0;
		more_data_d = 1'b0;
		dst_group_d = 1'b0;
		if (!pop_rec.crc_ok) begin
			status_d = STATUS_CRC_ERR;
		end else begin
			opcode_d   = op;
			last_blk_d = pop_rec.byte0[7];
			if (pop_rec.byte0[6]) begin
				status_d = STATUS_PROTECT;
			end else if (pop_rec.feature_nz) begin
				status_d = STATUS_FEATURE;
			end else if (!found) begin
				status_d = STATUS_UNKNOWN;
			end else begin
				kind_d   = match_idx;
				dst_id_d = pop_rec.dst_id;
				src_id_d = pop_rec.src_id;
				case (match_idx)
					KIND_VOICE_REQ: begin
						svc_opt_d = pop_rec.byte3;
					end
					KIND_VOICE_ANS: begin
						svc_opt_d = pop_rec.byte3;
						param_d   = pop_rec.dst_id[23:16];
					end
					KIND_NEG_ACK: begin
						param_d    = pop_rec.dst_id[23:16];
						src_type_d = pop_rec.byte3[6];
						svc_type_d = pop_rec.byte3[5:0];
					end
					KIND_PREAMBLE: begin
						param_d     = pop_rec.dst_id[23:16];
						more_data_d = pop_rec.byte3[7];
						dst_group_d = pop_rec.byte3[6];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			status      <= status_d;
			kind        <= kind_d;
			opcode      <= opcode_d;
			last_blk    <= last_blk_d;
			dst_id      <= dst_id_d;
			src_id      <= src_id_d;
			svc_options <= svc_opt_d;
			param_byte  <= param_d;
			src_type    <= src_type_d;
			svc_type    <= svc_type_d;
			more_data   <= more_data_d;
			group_call  <= dst_group_d;
		end
	end

endmodule

// ----- hdl/dmr_csbk_block_decoder.sv -----
// Control signalling block decoder: one byte item per cycle while in_ready is high, one result per 12-byte block.
// The result is registered: the block's record passes through the record queue and then the output register.
// Throughput: one byte per cycle while the queue has room; the bytewise CRC update sets the byte path.
// The front stalls whenever the record queue is full.
// Reset: byte count and CRC clear, queue empties, opcode registers load 56, 4, 5, 38, 61.
module dmr_csbk_block_decoder #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        block_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  kind,
	output logic [5:0]  opcode,
	output logic        last_blk,
	output logic [23:0] dst_id,
	output logic [23:0] src_id,
	output logic [7:0]  svc_options,
	output logic [7:0]  param_byte,
	output logic        src_type,
	output logic [5:0]  svc_type,
	output logic        more_data,
	output logic        group_call,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import csbk_pkg::*;

	block_rec_t push_rec;
	block_rec_t pop_rec;
	logic       push_valid;
	logic       push_ready;
	logic       pop_valid;
	logic       pop_ready;

	csbk_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.block_start (block_start),
		.push_ready  (push_ready),
		.push_valid  (push_valid),
		.push_rec    (push_rec)
	);

	csbk_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	csbk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_rec     (pop_rec),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.kind        (kind),
		.opcode      (opcode),
		.last_blk    (last_blk),
		.dst_id      (dst_id),
		.src_id      (src_id),
		.svc_options (svc_options),
		.param_byte  (param_byte),
		.src_type    (src_type),
		.svc_type    (svc_type),
		.more_data   (more_data),
		.group_call  (group_call)
	);

endmodule
